FILE: rtl/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// tmwf_pkg
// Shared widths, defaults and control types of the trimmed-mean window filter.
// ----------------------------------------------------------------------------
package tmwf_pkg;

    localparam int DATA_W         = 16;
    localparam int WINDOW_DEFAULT = 10;

    // stage enables for the trim / scale path
    typedef struct packed {
        logic trim_en;
        logic mul_en;
    } scale_ctl_t;

endpackage

FILE: rtl/tmwf_cell.sv
// ----------------------------------------------------------------------------
// tmwf_cell
// One window entry; takes its neighbor's value whenever the chain shifts.
// ----------------------------------------------------------------------------
module tmwf_cell
    import tmwf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic [DATA_W-1:0] d,
    output logic [DATA_W-1:0] q
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = shift ? d : val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign q = val_reg;

endmodule

FILE: rtl/tmwf_scaler.sv
// ----------------------------------------------------------------------------
// tmwf_scaler
// Trims max and min off the window sum, then divides by WINDOW-2 through an
// exact reciprocal multiply. Two register stages.
// ----------------------------------------------------------------------------
module tmwf_scaler
    import tmwf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                                 clk,
    input  scale_ctl_t                           ctl,
    input  logic [DATA_W+$clog2(WINDOW)-1:0]     sum,
    input  logic [DATA_W-1:0]                    hi,
    input  logic [DATA_W-1:0]                    lo,
    output logic [DATA_W-1:0]                    quot
);

    localparam int SUM_W  = DATA_W + $clog2(WINDOW);
    localparam int DIV    = WINDOW - 2;
    localparam int SHIFT  = SUM_W + $clog2(DIV);
    localparam int M_W    = SUM_W + 1;
    localparam int PROD_W = SUM_W + M_W;
    // ceil(2^SHIFT / DIV); error term stays below 2^clog2(DIV), so floor is exact
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

    logic [SUM_W-1:0]  trim_reg;
    logic [SUM_W-1:0]  trim_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb
    begin
        trim_next = ctl.trim_en ? (sum - SUM_W'(hi) - SUM_W'(lo)) : trim_reg;
        prod_next = ctl.mul_en ? (PROD_W'(trim_reg) * PROD_W'(RECIP)) : prod_reg;
    end

    always_ff @(posedge clk)
    begin
        trim_reg <= trim_next;
        prod_reg <= prod_next;
    end

    assign quot = prod_reg[SHIFT +: DATA_W];

endmodule

FILE: rtl/trimmed_mean_window_filter_unit.sv
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter_unit
// Steps from request to result valid: rotating scan of the whole window,
// trim, reciprocal multiply, output load (held while the output is stalled).
// A new request is accepted only in idle, after the last result is loaded,
// so requests never overlap in the rotating scan of the cell chain.
// Reset (async, active low) clears every window cell to zero and the control.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_unit
    import tmwf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] sample,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] filtered
);

    localparam int SUM_W = DATA_W + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_TRIM = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic              oval_reg, oval_next;
    logic [DATA_W-1:0] odata_reg, odata_next;

    logic              accept;
    logic              shift;
    logic [DATA_W-1:0] head_d;
    logic [DATA_W-1:0] tap [WINDOW];
    logic [DATA_W-1:0] tail;
    logic [DATA_W-1:0] quot;
    logic              out_free;
    scale_ctl_t        ctl;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign tail     = tap[WINDOW-1];
    assign out_free = !oval_reg || !out_stall;

    // new request shifts in at the head; scan rotates tail back to the head
    assign shift  = accept || (state_reg == ST_SCAN);
    assign head_d = accept ? sample : tail;

    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        tmwf_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     ((g == 0) ? head_d : tap[(g == 0) ? 0 : g-1]),
            .q     (tap[g])
        );
    end

    assign ctl.trim_en = (state_reg == ST_TRIM);
    assign ctl.mul_en  = (state_reg == ST_MUL);

    tmwf_scaler #(
        .WINDOW (WINDOW)
    ) u_scaler (
        .clk  (clk),
        .ctl  (ctl),
        .sum  (sum_reg),
        .hi   (hi_reg),
        .lo   (lo_reg),
        .quot (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        oval_next  = oval_reg && out_stall;
        odata_next = odata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    sum_next   = '0;
                    hi_next    = '0;
                    lo_next    = '1;
                end
            end
            ST_SCAN:
            begin
                sum_next = sum_reg + SUM_W'(tail);
                if (tail > hi_reg)
                begin
                    hi_next = tail;
                end
                if (tail < lo_reg)
                begin
                    lo_next = tail;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WINDOW-1))
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    odata_next = quot;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        sum_reg   <= sum_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        odata_reg <= odata_next;
    end

    assign out_valid = oval_reg;
    assign filtered  = odata_reg;

endmodule

FILE: test/trimmed_mean_window_filter_unit_checker.sv
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter_unit_checker
// Watches both channels of the filter. It keeps its own copy of the sample
// window, works out the trimmed mean for each accepted request and compares
// every accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_unit_checker
    import tmwf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [DATA_W-1:0] sample,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [DATA_W-1:0] filtered,
    output int                outstanding,
    output int                mismatches,
    output int                results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W = $clog2(WINDOW);

    logic [DATA_W-1:0] window_cells [WINDOW];
    logic [POS_W-1:0]  wr_pos;
    logic [DATA_W-1:0] expected_filtered_q [$];
    logic [DATA_W-1:0] want;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // drop one max and one min, divide by WINDOW-2 regardless of fill level
    function automatic logic [DATA_W-1:0] trimmed_window_mean();
        logic [31:0]       total;
        logic [DATA_W-1:0] top_val;
        logic [DATA_W-1:0] bottom_val;
        total      = '0;
        top_val    = '0;
        bottom_val = '1;
        for (int i = 0; i < WINDOW; i++)
        begin
            total = total + 32'(window_cells[i]);
            if (window_cells[i] > top_val)
                top_val = window_cells[i];
            if (window_cells[i] < bottom_val)
                bottom_val = window_cells[i];
        end
        total = total - 32'(top_val) - 32'(bottom_val);
        return DATA_W'(total / 32'(WINDOW - 2));
    endfunction

    initial
    begin
        mismatches   = 0;
        results_seen = 0;
        outstanding  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                window_cells[i] = '0;
            wr_pos = '0;
            expected_filtered_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first: a request accepted on this edge cannot answer here
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_filtered_q.size() == 0)
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              filtered));
                else
                begin
                    want = expected_filtered_q.pop_front();
                    if (filtered !== want)
                        report_mismatch($sformatf("filtered %0d, expected %0d",
                                                  filtered, want));
                end
            end
            if (in_valid && !in_stall)
            begin
                window_cells[wr_pos] = sample;
                wr_pos = (wr_pos == POS_W'(WINDOW - 1)) ? '0 : wr_pos + 1'b1;
                expected_filtered_q.push_back(trimmed_window_mean());
            end
            outstanding <= expected_filtered_q.size();
        end
    end

endmodule

FILE: test/trimmed_mean_window_filter_unit_test.sv
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter_unit_test
// Drives samples into the trimmed-mean filter: a directed set of
// extremes, ties and a partly filled window, then random samples over
// phases of sender gaps and receiver stalls, with long output hold-offs.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmwf_pkg::*;

    localparam int LATENCY     = WINDOW_DEFAULT + 4;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [DATA_W-1:0] sample;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] filtered;

    int outstanding;
    int mismatches;
    int results_seen;
    int idle_pct;
    int stall_pct;
    int hold_off_req;
    int hold_off_done;
    int hold_left;
    int cycle_count;
    int sent;
    logic [DATA_W-1:0] last_sample;

    trimmed_mean_window_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered)
    );

    trimmed_mean_window_filter_unit_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered     (filtered),
        .outstanding  (outstanding),
        .mismatches   (mismatches),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d requests still open",
                     cycle_count, outstanding);
            $display("trimmed_mean_window_filter_unit_test: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_off_req != hold_off_done)
            begin
                hold_off_done++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // ties, extremes, small values and plain random
    function automatic logic [DATA_W-1:0] pick_sample();
        logic [DATA_W-1:0] v;
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = '1;
            2:       v = last_sample;
            3:       v = DATA_W'($urandom_range(15));
            4:       v = 16'hFFFF - DATA_W'($urandom_range(15));
            default: v = DATA_W'($urandom);
        endcase
        last_sample = v;
        return v;
    endfunction

    task automatic send_request(input logic [DATA_W-1:0] value);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count,
                             input bit hold);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            if (hold && n == 20)
                hold_off_req++;
            send_request(pick_sample());
        end
        drain();
    endtask

    initial
    begin
        logic [DATA_W-1:0] directed [$];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample        = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_off_req  = 0;
        hold_off_done = 0;
        cycle_count   = 0;
        sent          = 0;
        last_sample   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window still mostly zero from reset, then extremes
        directed = '{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555};
        // all entries equal at the top value
        repeat (12) directed.push_back(16'hFFFF);
        // two mins among maxes, then repeated middle values with ties
        directed.push_back(16'h0000);
        directed.push_back(16'h0000);
        directed.push_back(16'hFFFF);
        directed.push_back(16'd100);
        directed.push_back(16'd100);
        directed.push_back(16'd100);
        directed.push_back(16'd5);
        foreach (directed[i])
            send_request(directed[i]);
        drain();

        run_phase(0, 0, 440, 1'b1);
        run_phase(62, 0, 430, 1'b0);
        run_phase(0, 62, 430, 1'b0);
        run_phase(31, 31, 425, 1'b1);

        repeat (4 * LATENCY) @(posedge clk);
        $display("covered %0d samples, %0d results, over sender gaps, receiver stalls",
                 sent, results_seen);
        $display("and %0d long output hold-offs with the input backed up", hold_off_done);
        if (mismatches == 0)
            $display("trimmed_mean_window_filter_unit_test: PASS");
        else
            $display("trimmed_mean_window_filter_unit_test: FAIL");
        $finish;
    end

endmodule
